// ----- sv/rpc_pkg.sv -----
// Shared types and constants for the replay position controller.
// No dependencies; imported by every module of the block.
package rpc_pkg;

    // Default width of entry positions
    localparam int POSITION_BITS_DEF = 32;

    // Field widths of the command and result transactions
    localparam int OP_W     = 2;
    localparam int MODE_W   = 2;
    localparam int AMOUNT_W = 31;
    localparam int LIVE_W   = 32;
    localparam int ENTRY_W  = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int MULT_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERLACED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MULT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSED     = 2'd3;

    // Command opcodes
    localparam logic [OP_W-1:0] OP_SEEK     = 2'd0;
    localparam logic [OP_W-1:0] OP_FRAME    = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_LEN  = 2'd2;

    // Seek modes
    localparam logic [MODE_W-1:0] SEEK_DIRECT = 2'd0;
    localparam logic [MODE_W-1:0] SEEK_FWD    = 2'd1;
    localparam logic [MODE_W-1:0] SEEK_BACK   = 2'd2;
    localparam logic [MODE_W-1:0] SEEK_LIVE   = 2'd3;

    // Distance kept behind the live edge on a live seek
    localparam int LIVE_BACKOFF = 4;

    // Configuration register contents
    typedef struct packed {
        logic              interlaced;
        logic [MULT_W-1:0] step_multiplier;
        logic              reverse;
        logic              paused;
    } t_cfg;

    // Result flags of one command
    typedef struct packed {
        logic fetch;
        logic reposition;
        logic hold_still;
    } t_flags;

endpackage

// ----- sv/replay_position_controller.sv -----
// Replay position controller: top level with command, state and result registers.
// A command in the input register passes through rpc_step into the result
// register once the result is not stalled. Throughput: one command per cycle
// while the result is not stalled; the position state closes its loop through
// one pass of rpc_step between the input register and the result register.
// Reset (synchronous, active low) clears the position state, handshake state
// and sets step_multiplier to 1; depends on rpc_pkg, rpc_cfg and rpc_step.
module replay_position_controller #(
    parameter int POSITION_BITS = rpc_pkg::POSITION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [rpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // command channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [rpc_pkg::OP_W-1:0]       i_op,
    input  logic [rpc_pkg::MODE_W-1:0]     i_seek_mode,
    input  logic [rpc_pkg::AMOUNT_W-1:0]   i_amount,
    input  logic [rpc_pkg::LIVE_W-1:0]     i_live_end,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [rpc_pkg::ENTRY_W-1:0]    o_entry_index,
    output logic                           o_fetch,
    output logic                           o_reposition,
    output logic                           o_hold_still,
    output logic [rpc_pkg::ENTRY_W-1:0]    o_position
);
    import rpc_pkg::*;

    localparam int XW = ((POSITION_BITS > ENTRY_W) ? POSITION_BITS : ENTRY_W);

    t_cfg cfg;

    rpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // handshake control
    logic r_in_valid;
    logic r_out_valid;
    logic in_accept;
    logic advance;

    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // command register
    logic [OP_W-1:0]     r_op;
    logic [MODE_W-1:0]   r_seek_mode;
    logic [AMOUNT_W-1:0] r_amount;
    logic [LIVE_W-1:0]   r_live_end;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op        <= i_op;
            r_seek_mode <= i_seek_mode;
            r_amount    <= i_amount;
            r_live_end  <= i_live_end;
        end
    end

    // position state
    logic [POSITION_BITS-1:0] r_position;
    logic [POSITION_BITS-1:0] r_first_position;
    logic [POSITION_BITS-1:0] r_end_limit;
    logic                     r_just_sought;
    logic                     r_still_held;

    logic [POSITION_BITS-1:0] n_position;
    logic [POSITION_BITS-1:0] n_first_position;
    logic [POSITION_BITS-1:0] n_end_limit;
    logic                     n_just_sought;
    logic                     n_still_held;
    logic [POSITION_BITS-1:0] n_entry;
    t_flags                   n_flags;

    rpc_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .i_cfg            (cfg),
        .i_op             (r_op),
        .i_seek_mode      (r_seek_mode),
        .i_amount         (r_amount),
        .i_live_end       (r_live_end),
        .i_position       (r_position),
        .i_first_position (r_first_position),
        .i_end_limit      (r_end_limit),
        .i_just_sought    (r_just_sought),
        .i_still_held     (r_still_held),
        .o_position       (n_position),
        .o_first_position (n_first_position),
        .o_end_limit      (n_end_limit),
        .o_just_sought    (n_just_sought),
        .o_still_held     (n_still_held),
        .o_entry          (n_entry),
        .o_flags          (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position       <= '0;
            r_first_position <= '0;
            r_end_limit      <= '0;
            r_just_sought    <= 1'b0;
            r_still_held     <= 1'b0;
        end else if (advance) begin
            r_position       <= n_position;
            r_first_position <= n_first_position;
            r_end_limit      <= n_end_limit;
            r_just_sought    <= n_just_sought;
            r_still_held     <= n_still_held;
        end
    end

    // result register, low 32 bits of the positions
    logic [ENTRY_W-1:0] r_entry_index;
    logic [ENTRY_W-1:0] r_out_position;
    t_flags             r_flags;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_entry_index  <= ENTRY_W'(XW'(n_entry));
            r_out_position <= ENTRY_W'(XW'(n_position));
            r_flags        <= n_flags;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_entry_index = r_entry_index;
    assign o_position    = r_out_position;
    assign o_fetch       = r_flags.fetch;
    assign o_reposition  = r_flags.reposition;
    assign o_hold_still  = r_flags.hold_still;

endmodule

// ----- sv/rpc_cfg.sv -----
// Configuration register file of the replay position controller.
// Depends on rpc_pkg.
module rpc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rpc_pkg::t_cfg                  o_cfg
);
    import rpc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode one register write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INTERLACED: n_cfg.interlaced      = i_cfg_data[0];
                CFG_STEP_MULT:  n_cfg.step_multiplier = i_cfg_data[MULT_W-1:0];
                CFG_REVERSE:    n_cfg.reverse         = i_cfg_data[0];
                CFG_PAUSED:     n_cfg.paused          = i_cfg_data[0];
                default:        n_cfg                 = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interlaced      <= 1'b0;
            r_cfg.step_multiplier <= MULT_W'(1);
            r_cfg.reverse         <= 1'b0;
            r_cfg.paused          <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/rpc_step.sv -----
// Combinational command evaluation: next position state and result fields.
// Depends on rpc_pkg.
module rpc_step #(
    parameter int POSITION_BITS = rpc_pkg::POSITION_BITS_DEF
) (
    input  rpc_pkg::t_cfg                  i_cfg,
    input  logic [rpc_pkg::OP_W-1:0]       i_op,
    input  logic [rpc_pkg::MODE_W-1:0]     i_seek_mode,
    input  logic [rpc_pkg::AMOUNT_W-1:0]   i_amount,
    input  logic [rpc_pkg::LIVE_W-1:0]     i_live_end,
    input  logic [POSITION_BITS-1:0]       i_position,
    input  logic [POSITION_BITS-1:0]       i_first_position,
    input  logic [POSITION_BITS-1:0]       i_end_limit,
    input  logic                           i_just_sought,
    input  logic                           i_still_held,
    output logic [POSITION_BITS-1:0]       o_position,
    output logic [POSITION_BITS-1:0]       o_first_position,
    output logic [POSITION_BITS-1:0]       o_end_limit,
    output logic                           o_just_sought,
    output logic                           o_still_held,
    output logic [POSITION_BITS-1:0]       o_entry,
    output rpc_pkg::t_flags                o_flags
);
    import rpc_pkg::*;

    // working width: holds any sum of two saturated positions or 32-bit inputs
    localparam int WB = ((POSITION_BITS > LIVE_W) ? POSITION_BITS : LIVE_W) + 2;

    localparam logic [WB-1:0] POS_MAX = WB'({POSITION_BITS{1'b1}});

    logic [WB-1:0]     live_w;
    logic [WB-1:0]     live_raw;
    logic [WB-1:0]     amt_w;
    logic [WB-1:0]     pos_w;
    logic [WB-1:0]     fwd_sum;
    logic [WB-1:0]     back_dist;
    logic [WB-1:0]     seek_pos;
    logic [WB-1:0]     mult_w;
    logic [WB-1:0]     step_sum;
    logic [WB-1:0]     step_pos;
    logic [WB-1:0]     len_sum;
    logic [WB-1:0]     len_sat;
    logic [WB-1:0]     len_dbl;
    logic [WB-1:0]     len_val;
    logic [MULT_W-1:0] mult;
    logic              limit_on;
    logic              eof;
    logic              step_repos;

    // operand alignment
    always_comb begin
        live_raw = WB'(i_live_end);
        live_w   = (live_raw > POS_MAX) ? POS_MAX : live_raw;
        amt_w    = i_cfg.interlaced ? WB'({i_amount, 1'b0}) : WB'(i_amount);
        pos_w    = WB'(i_position);
    end

    // seek target
    always_comb begin
        fwd_sum   = pos_w + amt_w;
        back_dist = amt_w + WB'(LIVE_BACKOFF);
        case (i_seek_mode)
            SEEK_DIRECT: seek_pos = (amt_w > live_w) ? live_w : amt_w;
            SEEK_FWD:    seek_pos = (fwd_sum > live_w) ? live_w : fwd_sum;
            SEEK_BACK:   seek_pos = (pos_w < amt_w) ? '0 : pos_w - amt_w;
            SEEK_LIVE:   seek_pos = (live_w < back_dist) ? '0 : live_w - back_dist;
            default:     seek_pos = pos_w;
        endcase
    end

    // end-of-play test and playback step
    always_comb begin
        mult     = (i_cfg.step_multiplier > MULT_W'(1)) ? i_cfg.step_multiplier
                                                          : MULT_W'(1);
        mult_w   = WB'(mult);
        limit_on = (i_end_limit != '0);
        eof = !i_just_sought && (
              i_cfg.paused
           || ( i_cfg.reverse && (i_position == '0))
           || (!i_cfg.reverse && (pos_w >= live_w))
           || (limit_on &&  i_cfg.reverse && (i_first_position >= i_position))
           || (limit_on && !i_cfg.reverse && (i_end_limit <= i_position)));
        step_sum = pos_w + mult_w;
        if (i_cfg.reverse) begin
            step_pos   = (pos_w < mult_w) ? '0 : pos_w - mult_w;
            step_repos = 1'b1;
        end else if (step_sum >= live_w) begin
            step_pos   = live_w;
            step_repos = 1'b1;
        end else begin
            step_pos   = step_sum;
            step_repos = (mult > MULT_W'(1));
        end
    end

    // play length limit, relative to half the last seek position
    always_comb begin
        len_sum = WB'(i_first_position >> 1) + WB'(i_amount);
        len_sat = (len_sum > POS_MAX) ? POS_MAX : len_sum;
        len_dbl = len_sat + len_sat;
        if (i_cfg.interlaced) begin
            len_val = (len_dbl > POS_MAX) ? POS_MAX : len_dbl;
        end else begin
            len_val = len_sat;
        end
    end

    // command dispatch
    always_comb begin
        o_position       = i_position;
        o_first_position = i_first_position;
        o_end_limit      = i_end_limit;
        o_just_sought    = i_just_sought;
        o_still_held     = i_still_held;
        o_entry          = '0;
        o_flags          = '0;
        case (i_op)
            OP_SEEK: begin
                o_position         = POSITION_BITS'(seek_pos);
                o_first_position   = POSITION_BITS'(seek_pos);
                o_just_sought      = 1'b1;
                o_entry            = POSITION_BITS'(seek_pos);
                o_flags.reposition = 1'b1;
            end
            OP_FRAME: begin
                o_entry = i_position;
                if (eof && i_still_held) begin
                    o_flags.hold_still = 1'b1;
                end else begin
                    o_just_sought      = 1'b0;
                    o_flags.fetch      = 1'b1;
                    o_position         = POSITION_BITS'(step_pos);
                    o_flags.reposition = step_repos;
                    o_still_held       = i_cfg.paused || eof;
                end
            end
            OP_SET_LEN: begin
                o_end_limit = (i_amount == '0) ? '0 : POSITION_BITS'(len_val);
            end
            default: begin
                o_position = i_position;
            end
        endcase
    end

endmodule
